/* design/assert_macros.svh */
// Assertion macros shared by the queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is held.
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/spq_pkg.sv */
// Types, constants and request codes for the stable sorted priority queue.
package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int DATA_WIDTH  = 32;
  localparam int PRIO_WIDTH  = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  typedef struct packed {
    logic                         req_type;
    logic signed [PRIO_WIDTH-1:0] entry_priority_in;
    logic [DATA_WIDTH-1:0]        datum_in;
  } spq_in_t;

  typedef struct packed {
    logic                  served;
    logic [DATA_WIDTH-1:0] datum_out;
    logic [CNT_W-1:0]      fill_count;
  } spq_out_t;

  // Contents of one cell.
  typedef struct packed {
    logic signed [PRIO_WIDTH-1:0] prio;
    logic [DATA_WIDTH-1:0]        datum;
  } spq_entry_t;

  // Command broadcast to every cell.
  typedef struct packed {
    logic       ins;
    logic       rem;
    spq_entry_t entry;
  } spq_cmd_t;

endpackage

/* design/stable_sorted_priority_queue_top.sv */
// Stable sorted priority queue: a chain of compare-and-shift cells.
// A result item is registered and appears in the cycle after its request item is accepted.
// Throughput: one request item per cycle while the output is not stalled; every cell compares and shifts in parallel.
// in_ready drops only while a finished result waits on a stalled output.
// Reset (rst_n low, synchronous) empties the queue and clears the output valid.
// Cell contents are not reset; only cells below the fill count are ever read.
`include "assert_macros.svh"

module stable_sorted_priority_queue_top (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  spq_pkg::spq_in_t in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output spq_pkg::spq_out_t out_item
);
  import spq_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  spq_out_t         out_item_r, out_item_nxt;

  logic     in_accept;
  logic     full, empty;
  spq_cmd_t cmd;

  spq_entry_t cell_entry [QUEUE_DEPTH];
  logic       cell_gt    [QUEUE_DEPTH];
  logic       cell_occ   [QUEUE_DEPTH];

  // Output register parts the two sides; a new item enters as the old leaves.
  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty = (count_r == '0);

  // Insert into a full queue and remove from an empty one are refused.
  assign cmd.ins         = in_accept && (in_item.req_type == REQ_INSERT) && !full;
  assign cmd.rem         = in_accept && (in_item.req_type == REQ_REMOVE) && !empty;
  assign cmd.entry.prio  = in_item.entry_priority_in;
  assign cmd.entry.datum = in_item.datum_in;

  // Cell chain: cell 0 holds the front (smallest priority, oldest among ties).
  // On insert each cell keeps, takes the new entry, or takes its left neighbor;
  // on remove each cell takes its right neighbor.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    spq_entry_t left_e, right_e;
    logic       left_g;

    assign cell_occ[i] = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_first
      assign left_g = 1'b0;
      assign left_e = cmd.entry;
    end else begin : g_mid
      assign left_g = cell_gt[i-1];
      assign left_e = cell_entry[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occ         (cell_occ[i]),
      .left_gt     (left_g),
      .left_entry  (left_e),
      .right_entry (right_e),
      .gt          (cell_gt[i]),
      .entry       (cell_entry[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.rem) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    out_item_nxt.served     = cmd.ins || cmd.rem;
    out_item_nxt.datum_out  = cmd.rem ? cell_entry[0].datum : '0;
    out_item_nxt.fill_count = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_item_r <= out_item_nxt;
    end
  end

  `SPQ_ASSERT_ALWAYS(a_count_bound, (!rst_n || count_r <= CNT_W'(QUEUE_DEPTH)), "fill count past depth")
  `SPQ_ASSERT(a_ins_grows, (cmd.ins |=> (count_r == $past(count_r) + CNT_W'(1))), "insert did not grow queue")
  `SPQ_ASSERT(a_refused_stable, ((in_accept && !cmd.ins && !cmd.rem) |=> $stable(count_r)), "refused request changed count")
  `SPQ_ASSERT(a_unserved_zero, ((out_valid && !out_item.served) |-> (out_item.datum_out == '0)), "unserved result carries data")

endmodule

/* design/spq_cell.sv */
// One storage cell of the sorted shift chain.
module spq_cell (
  input  logic               clk,
  input  spq_pkg::spq_cmd_t  cmd,
  input  logic               occ,
  input  logic               left_gt,
  input  spq_pkg::spq_entry_t left_entry,
  input  spq_pkg::spq_entry_t right_entry,
  output logic               gt,
  output spq_pkg::spq_entry_t entry
);
  import spq_pkg::*;

  spq_entry_t entry_r, entry_nxt;

  // Cell must make room: empty, or holds a strictly larger priority.
  assign gt    = !occ || (entry_r.prio > cmd.entry.prio);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.ins) begin
      if (left_gt) begin
        entry_nxt = left_entry;
      end else if (gt) begin
        entry_nxt = cmd.entry;
      end
    end else if (cmd.rem) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

/* tb/sv/stable_sorted_priority_queue_top_test.sv */
// Self-checking testbench for the stable sorted priority queue: random traffic with a shadow model.
module stable_sorted_priority_queue_top_test;
  import spq_pkg::*;

  localparam int RANDOM_ITEMS   = 750;
  localparam int CALM_TAIL      = 100;   // last items run with no idling
  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no handshake at all
  localparam int DRAIN_CYCLES   = 8;     // wait after the last result, with some slack

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  spq_in_t  in_item   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  spq_out_t out_item;

  stable_sorted_priority_queue_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Request items still to be sent, and results the shadow queue says are due.
  spq_in_t  pending_requests[$];
  spq_out_t due_results[$];

  // Shadow copy of the queue contents, kept sorted like the block's cells.
  logic signed [PRIO_WIDTH-1:0] shadow_prio[QUEUE_DEPTH];
  logic [DATA_WIDTH-1:0]        shadow_datum[QUEUE_DEPTH];
  int                           shadow_count = 0;

  int error_cnt    = 0;
  int accepted_cnt = 0;
  int idle_cycles  = 0;
  int in_gap       = 0;
  int out_gap      = 0;

  task automatic report_mismatch(input string what);
    $display("ERROR @%0t: %s", $time, what);
    error_cnt++;
  endtask

  // Apply one request to the shadow queue and return the result it must produce.
  function automatic spq_out_t serve_request(input spq_in_t req);
    spq_out_t res;
    int       pos;
    res = '0;
    if (req.req_type == REQ_INSERT) begin
      if (shadow_count < QUEUE_DEPTH) begin
        // Walk back over strictly larger priorities only: ties stay ahead (FIFO).
        pos = shadow_count;
        while (pos > 0 && shadow_prio[pos-1] > req.entry_priority_in) begin
          shadow_prio[pos]  = shadow_prio[pos-1];
          shadow_datum[pos] = shadow_datum[pos-1];
          pos--;
        end
        shadow_prio[pos]  = req.entry_priority_in;
        shadow_datum[pos] = req.datum_in;
        shadow_count++;
        res.served = 1'b1;
      end
    end else begin
      if (shadow_count > 0) begin
        res.datum_out = shadow_datum[0];
        for (int k = 1; k < shadow_count; k++) begin
          shadow_prio[k-1]  = shadow_prio[k];
          shadow_datum[k-1] = shadow_datum[k];
        end
        shadow_count--;
        res.served = 1'b1;
      end
    end
    res.fill_count = CNT_W'(shadow_count);
    return res;
  endfunction

  task automatic queue_request(input logic kind, input logic [PRIO_WIDTH-1:0] prio,
                               input logic [DATA_WIDTH-1:0] datum);
    spq_in_t req;
    req.req_type          = kind;
    req.entry_priority_in = prio;
    req.datum_in          = datum;
    pending_requests.push_back(req);
  endtask

  // Random priority: mostly narrow sets so ties and reordering are common.
  function automatic logic [PRIO_WIDTH-1:0] pick_priority();
    case ($urandom_range(0, 3))
      0:       return PRIO_WIDTH'($signed($urandom_range(0, 4)) - 2);
      1:       return PRIO_WIDTH'($urandom);
      2:       return $urandom_range(0, 1) ? {1'b1, {(PRIO_WIDTH-1){1'b0}}}
                                           : {1'b0, {(PRIO_WIDTH-1){1'b1}}};
      default: return PRIO_WIDTH'($urandom_range(0, 7) * 1000);
    endcase
  endfunction

  // Idling is switched off near the end and in some windows of the run.
  function automatic bit idling_allowed();
    return pending_requests.size() >= CALM_TAIL && ((accepted_cnt / 64) % 3 != 0);
  endfunction

  // Driver: offers pending items, holds each until accepted, predicts on acceptance.
  always @(posedge clk) begin
    logic fire;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      fire = in_valid && in_ready;
      if (fire) begin
        due_results.push_back(serve_request(in_item));
        accepted_cnt++;
      end
      if (in_valid && !fire) begin
        // item still waiting: keep valid and payload as they are
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        if (idling_allowed() && $urandom_range(0, 7) == 0) begin
          in_gap = $urandom_range(0, 13);  // idle now; in_gap holds the rest of the gap
          in_valid <= 1'b0;
        end else begin
          in_item  <= pending_requests.pop_front();
          in_valid <= 1'b1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks every accepted result against the oldest prediction and
  // throttles out_ready in random bursts.
  always @(posedge clk) begin
    spq_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result served=%0b datum=%h fill=%0d",
                                    out_item.served, out_item.datum_out, out_item.fill_count));
        end else begin
          want = due_results.pop_front();
          if (out_item.served !== want.served)
            report_mismatch($sformatf("served got %b want %b",
                                      out_item.served, want.served));
          if (out_item.datum_out !== want.datum_out)
            report_mismatch($sformatf("datum_out got %h want %h",
                                      out_item.datum_out, want.datum_out));
          if (out_item.fill_count !== want.fill_count)
            report_mismatch($sformatf("fill_count got %0d want %0d",
                                      out_item.fill_count, want.fill_count));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(0, 13);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: any handshake on either side restarts the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL stable_sorted_priority_queue_top");
        $finish;
      end
    end
  end

  initial begin
    int made;
    int seg_len;
    int insert_pct;

    // Directed part: remove on empty, extremes, ties, fill to full, refused insert, removes.
    queue_request(REQ_REMOVE, '1, '1);                        // empty: not served
    queue_request(REQ_INSERT, 16'h7FFF, 32'hFFFF_FFFF);       // largest priority
    queue_request(REQ_INSERT, 16'h8000, 32'h0000_0000);       // smallest, goes to front
    queue_request(REQ_INSERT, 16'h0000, 32'hA000_0001);       // three ties keep FIFO
    queue_request(REQ_INSERT, 16'h0000, 32'hA000_0002);
    queue_request(REQ_INSERT, 16'h0000, 32'hA000_0003);
    queue_request(REQ_INSERT, 16'hFFFF, 32'h5555_5555);       // -1 lands before zeros
    queue_request(REQ_INSERT, 16'h8000, 32'hAAAA_AAAA);       // tie at the minimum
    for (int i = 0; i < 9; i++)
      queue_request(REQ_INSERT, PRIO_WIDTH'(i * 3 - 10), DATA_WIDTH'(32'hC0DE_0000 + i));
    queue_request(REQ_INSERT, 16'h8000, 32'hDEAD_BEEF);       // full: refused
    queue_request(REQ_REMOVE, 16'h0000, 32'h0000_0000);
    queue_request(REQ_REMOVE, 16'h7FFF, 32'hFFFF_FFFF);
    queue_request(REQ_REMOVE, 16'h8000, 32'h1234_5678);

    // Random part: segments biased toward filling, draining, or balanced traffic.
    made = 0;
    while (made < RANDOM_ITEMS) begin
      seg_len = $urandom_range(20, 60);
      case ($urandom_range(0, 2))
        0:       insert_pct = 15;
        1:       insert_pct = 50;
        default: insert_pct = 85;
      endcase
      for (int i = 0; i < seg_len && made < RANDOM_ITEMS; i++) begin
        if ($urandom_range(0, 99) < insert_pct)
          queue_request(REQ_INSERT, pick_priority(), DATA_WIDTH'($urandom));
        else
          queue_request(REQ_REMOVE, PRIO_WIDTH'($urandom), DATA_WIDTH'($urandom));
        made++;
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every item to go in and every result to come back.
    while (pending_requests.size() != 0 || in_valid || due_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_cnt == 0) begin
      $display("PASS stable_sorted_priority_queue_top");
    end else begin
      $display("FAIL stable_sorted_priority_queue_top");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/spq_pkg.sv
design/spq_cell.sv
design/stable_sorted_priority_queue_top.sv
tb/sv/stable_sorted_priority_queue_top_test.sv
